[rtl/lpa_pkg.sv]
// ----------------------------------------------------------------------------
// LRU priority arbiter package
// Shared constants and types for the arbiter and its order cells.
// ----------------------------------------------------------------------------
`default_nettype none

package lpa_pkg;

  localparam int unsigned MaxRequesters = 16;
  localparam int unsigned IdxW = $clog2(MaxRequesters);
  localparam int unsigned CntW = $clog2(MaxRequesters + 1);
  localparam int unsigned CfgDataW = 5;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_CHILD_COUNT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DYNAMIC_MODE = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_REVERSE_DIRECTION = 2'd2;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;
  typedef logic [MaxRequesters-1:0] mask_t;

  typedef struct packed {
    logic load;
    logic init;
    logic in_range;
    logic last;
    logic grant;
  } cell_ctl_t;

endpackage

`default_nettype wire

[rtl/lpa_cell.sv]
// ----------------------------------------------------------------------------
// LRU priority arbiter order cell
// Holds one place of the priority order, checks its requester and shifts
// toward the front when a grant is taken at or ahead of it.
// ----------------------------------------------------------------------------
`default_nettype none

module lpa_cell (
  input  wire                 clk_i,
  input  lpa_pkg::cell_ctl_t  ctl_i,
  input  lpa_pkg::idx_t       init_val_i,
  input  lpa_pkg::idx_t       nbr_i,
  input  lpa_pkg::mask_t      mask_i,
  input  wire                 found_i,
  input  lpa_pkg::idx_t       win_i,
  input  lpa_pkg::idx_t       winner_i,
  output lpa_pkg::idx_t       eff_o,
  output logic                found_o,
  output lpa_pkg::idx_t       win_o
);

  lpa_pkg::idx_t order_q, order_d;
  logic          hit;

  assign eff_o   = ctl_i.init ? init_val_i : order_q;
  assign hit     = ctl_i.in_range & mask_i[eff_o];
  assign found_o = found_i | hit;
  assign win_o   = (hit && !found_i) ? eff_o : win_i;

  always_comb begin
    if (ctl_i.grant && ctl_i.last) begin
      order_d = winner_i;
    end else if (ctl_i.grant && found_o && ctl_i.in_range) begin
      order_d = nbr_i;
    end else begin
      order_d = eff_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      order_q <= order_d;
    end
  end

endmodule

`default_nettype wire

[rtl/lru_priority_arbiter_unit.sv]
// ----------------------------------------------------------------------------
// LRU priority arbiter
// Grants one requester per item, by fixed priority or least recently granted.
// ----------------------------------------------------------------------------
// The block takes one request mask per cycle and returns its grant in the
// output register in the cycle after the item is accepted; a new item is taken
// whenever the output register is empty or being read. The dynamic order is
// held in a row of sixteen cells, and the longest path is the scan for the
// first requesting cell through that row followed by the shift of every cell
// at and behind the winner.
`default_nettype none

module lru_priority_arbiter_unit (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire [lpa_pkg::MaxRequesters-1:0] request_mask_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic                             grant_valid_o,
  output logic [3:0]                       grant_index_o,
  input  wire                              cfg_we_i,
  input  wire [lpa_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire [lpa_pkg::CfgDataW-1:0]      cfg_wdata_i
);

  localparam int unsigned N = lpa_pkg::MaxRequesters;

  logic [lpa_pkg::CfgDataW-1:0] child_count_q;
  logic                         dynamic_mode_q;
  logic                         reverse_q;
  logic                         built_q, built_d;
  logic                         out_valid_q;
  logic                         grant_valid_q;
  lpa_pkg::idx_t                grant_index_q;

  lpa_pkg::cnt_t  n_eff;
  logic           accept;
  logic           load;
  logic           use_init;
  lpa_pkg::idx_t  eff   [N];
  lpa_pkg::idx_t  win   [N+1];
  logic           found [N+1];
  lpa_pkg::idx_t  nbr   [N];
  lpa_pkg::idx_t  init_val [N];
  lpa_pkg::cell_ctl_t ctl [N];

  assign n_eff = (child_count_q > lpa_pkg::CfgDataW'(N)) ? lpa_pkg::CntW'(N)
                                                          : lpa_pkg::CntW'(child_count_q);

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign use_init   = !dynamic_mode_q || !built_q;
  assign load       = accept && dynamic_mode_q && (n_eff != '0);

  assign found[0] = 1'b0;
  assign win[0]   = '0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    lpa_pkg::cnt_t pos;
    assign pos = lpa_pkg::CntW'(g);
    assign init_val[g] = reverse_q ? lpa_pkg::IdxW'(n_eff - pos - lpa_pkg::CntW'(1))
                                   : lpa_pkg::IdxW'(pos);
    assign nbr[g] = (g == N - 1) ? '0 : eff[(g + 1) % N];
    assign ctl[g] = '{
      load:     load,
      init:     use_init,
      in_range: pos < n_eff,
      last:     pos == (n_eff - lpa_pkg::CntW'(1)),
      grant:    found[N]
    };

    lpa_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl[g]),
      .init_val_i (init_val[g]),
      .nbr_i      (nbr[g]),
      .mask_i     (request_mask_i),
      .found_i    (found[g]),
      .win_i      (win[g]),
      .winner_i   (win[N]),
      .eff_o      (eff[g]),
      .found_o    (found[g+1]),
      .win_o      (win[g+1])
    );
  end

  always_comb begin
    built_d = built_q;
    if (cfg_we_i && (cfg_idx_i == lpa_pkg::CFG_CHILD_COUNT ||
                     cfg_idx_i == lpa_pkg::CFG_DYNAMIC_MODE ||
                     cfg_idx_i == lpa_pkg::CFG_REVERSE_DIRECTION)) begin
      built_d = 1'b0;
    end else if (load) begin
      built_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      child_count_q  <= '0;
      dynamic_mode_q <= 1'b0;
      reverse_q      <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lpa_pkg::CFG_CHILD_COUNT:       child_count_q  <= cfg_wdata_i;
        lpa_pkg::CFG_DYNAMIC_MODE:      dynamic_mode_q <= cfg_wdata_i[0];
        lpa_pkg::CFG_REVERSE_DIRECTION: reverse_q      <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      built_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      built_q <= built_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      grant_valid_q <= found[N];
      grant_index_q <= win[N];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign grant_valid_o = grant_valid_q;
  assign grant_index_o = grant_index_q;

endmodule

`default_nettype wire

[rtl/lpa_checker.sv]
// ----------------------------------------------------------------------------
// LRU priority arbiter checker
// Port-level assertions on the arbiter, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module lpa_checker (
  input wire                              clk_i,
  input wire                              rst_ni,
  input wire                              in_valid_i,
  input wire                              in_ready_o,
  input wire [lpa_pkg::MaxRequesters-1:0] request_mask_i,
  input wire                              out_valid_o,
  input wire                              out_ready_i,
  input wire                              grant_valid_o,
  input wire [3:0]                        grant_index_o
);

  // A result that has not been taken holds still.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(grant_valid_o) && $stable(grant_index_o))
    else $error("result changed while stalled");

  // An accepted item shows its result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted item produced no result");

  // The granted requester was active in the accepted mask.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=>
      !grant_valid_o || ((($past(request_mask_i) >> grant_index_o) & 16'd1) != 16'd0))
    else $error("grant to an inactive requester");

  // An empty grant carries index zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !grant_valid_o |-> grant_index_o == 4'd0)
    else $error("nonzero index without a grant");

endmodule

bind lru_priority_arbiter_unit lpa_checker u_lpa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .request_mask_i (request_mask_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .grant_valid_o  (grant_valid_o),
  .grant_index_o  (grant_index_o)
);

`default_nettype wire

[tb/lru_priority_arbiter_unit_test.sv]
// ----------------------------------------------------------------------------
// LRU priority arbiter testbench
// Drives request masks through the arbiter under both fixed and rotating
// priority, with random idle cycles on both sides. A local predictor keeps its
// own copy of the settings and of the grant order, and every grant that comes
// out is checked in order against the prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lru_priority_arbiter_unit_test;

  localparam logic [lpa_pkg::CfgIdxW-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic granted;
    lpa_pkg::idx_t index;
  } grant_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  lpa_pkg::mask_t               request_mask_i;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic                         grant_valid_o;
  logic [3:0]                   grant_index_o;
  logic                         cfg_we_i;
  logic [lpa_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [lpa_pkg::CfgDataW-1:0] cfg_wdata_i;

  lpa_pkg::cnt_t arb_count;
  logic          arb_dynamic;
  logic          arb_reverse;
  lpa_pkg::idx_t rank_list [lpa_pkg::MaxRequesters];
  logic          rank_built;
  grant_t        pending_grants [$];
  int            mismatch_count;
  logic          steady;

  lru_priority_arbiter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .request_mask_i(request_mask_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .grant_valid_o (grant_valid_o),
    .grant_index_o (grant_index_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit take_pause();
    return !steady && ($urandom_range(0, 99) < 16);
  endfunction

  function automatic int used_count();
    return (arb_count > lpa_pkg::cnt_t'(lpa_pkg::MaxRequesters)) ?
           int'(lpa_pkg::MaxRequesters) : int'(arb_count);
  endfunction

  function automatic grant_t arbitrate_request(lpa_pkg::mask_t mask);
    grant_t        g;
    int            n;
    int            i;
    int            k;
    lpa_pkg::idx_t who;
    g = '0;
    n = used_count();
    if (arb_dynamic) begin
      if (!rank_built && n > 0) begin
        for (i = 0; i < n; i++) begin
          rank_list[i] = arb_reverse ? lpa_pkg::idx_t'(n - 1 - i) : lpa_pkg::idx_t'(i);
        end
        rank_built = 1'b1;
      end
      if (rank_built) begin
        for (i = 0; i < n && !g.granted; i++) begin
          who = rank_list[i];
          if (mask[who]) begin
            for (k = i + 1; k < n; k++) begin
              rank_list[k - 1] = rank_list[k];
            end
            rank_list[n - 1] = who;
            g.granted = 1'b1;
            g.index = who;
          end
        end
      end
    end else if (!arb_reverse) begin
      for (i = 0; i < n && !g.granted; i++) begin
        if (mask[i]) begin
          g.granted = 1'b1;
          g.index = lpa_pkg::idx_t'(i);
        end
      end
    end else begin
      for (i = n - 1; i >= 0 && !g.granted; i--) begin
        if (mask[i]) begin
          g.granted = 1'b1;
          g.index = lpa_pkg::idx_t'(i);
        end
      end
    end
    return g;
  endfunction

  function automatic lpa_pkg::mask_t random_mask();
    int             sel;
    lpa_pkg::mask_t m;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      m = lpa_pkg::mask_t'($urandom);
    end else if (sel < 7) begin
      m = lpa_pkg::mask_t'($urandom & $urandom & $urandom);
    end else if (sel == 7) begin
      m = lpa_pkg::mask_t'(1) << $urandom_range(0, lpa_pkg::MaxRequesters - 1);
    end else if (sel == 8) begin
      m = $urandom_range(0, 1) ? '0 : '1;
    end else begin
      m = lpa_pkg::mask_t'($urandom) & lpa_pkg::mask_t'((32'd1 << used_count()) - 1);
    end
    return m;
  endfunction

  task automatic send_request(lpa_pkg::mask_t mask);
    grant_t g;
    if (take_pause()) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (take_pause());
    end
    in_valid_i <= 1'b1;
    request_mask_i <= mask;
    do @(posedge clk_i); while (!in_ready_o);
    g = arbitrate_request(mask);
    pending_grants.push_back(g);
  endtask

  task automatic drain_grants();
    in_valid_i <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [lpa_pkg::CfgIdxW-1:0] idx,
                           logic [lpa_pkg::CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      lpa_pkg::CFG_CHILD_COUNT: begin
        arb_count = data;
        rank_built = 1'b0;
      end
      lpa_pkg::CFG_DYNAMIC_MODE: begin
        arb_dynamic = data[0];
        rank_built = 1'b0;
      end
      lpa_pkg::CFG_REVERSE_DIRECTION: begin
        arb_reverse = data[0];
        rank_built = 1'b0;
      end
      default: begin
      end
    endcase
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= !take_pause();
  end

  always @(posedge clk_i) begin
    grant_t g;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_grants.size() == 0) begin
        $error("grant with nothing expected: grant_valid %0d grant_index %0d",
               grant_valid_o, grant_index_o);
        mismatch_count++;
      end else begin
        g = pending_grants.pop_front();
        if (grant_valid_o !== g.granted) begin
          $error("grant_valid: expected %0d, actual %0d", g.granted, grant_valid_o);
          mismatch_count++;
        end
        if (grant_index_o !== g.index) begin
          $error("grant_index: expected %0d, actual %0d", g.index, grant_index_o);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_static_priority();
    send_request('1);
    drain_grants();
    write_reg(lpa_pkg::CFG_CHILD_COUNT, 5'd16);
    send_request('1);
    send_request(16'h8000);
    send_request(16'h0000);
    send_request(16'h0a50);
    drain_grants();
    write_reg(lpa_pkg::CFG_REVERSE_DIRECTION, 5'd1);
    send_request('1);
    send_request(16'h0001);
    drain_grants();
    write_reg(lpa_pkg::CFG_CHILD_COUNT, 5'd31);
    send_request(16'h8001);
    drain_grants();
    write_reg(lpa_pkg::CFG_CHILD_COUNT, 5'd1);
    send_request(16'hfffe);
    send_request(16'h0001);
    drain_grants();
  endtask

  task automatic test_dynamic_rotation();
    write_reg(lpa_pkg::CFG_REVERSE_DIRECTION, 5'd0);
    write_reg(lpa_pkg::CFG_CHILD_COUNT, 5'd0);
    write_reg(lpa_pkg::CFG_DYNAMIC_MODE, 5'd1);
    send_request('1);
    drain_grants();
    write_reg(lpa_pkg::CFG_CHILD_COUNT, 5'd4);
    send_request(16'h0000);
    send_request(16'h000f);
    send_request(16'h000f);
    send_request(16'h0001);
    drain_grants();
    // A write to the unused index must leave the built order alone.
    write_reg(CFG_UNUSED, 5'd31);
    send_request(16'h00ff);
    drain_grants();
    write_reg(lpa_pkg::CFG_REVERSE_DIRECTION, 5'd1);
    send_request(16'h000f);
    send_request(16'h0009);
    drain_grants();
    write_reg(lpa_pkg::CFG_CHILD_COUNT, 5'd17);
    send_request('1);
    send_request('1);
    drain_grants();
  endtask

  task automatic test_random_traffic();
    int phase;
    int j;
    int r;
    for (phase = 0; phase < 6; phase++) begin
      drain_grants();
      if (phase == 4) begin
        write_reg(CFG_UNUSED, 5'($urandom_range(0, 31)));
      end else begin
        r = $urandom_range(0, 9);
        if (phase == 0) begin
          write_reg(lpa_pkg::CFG_CHILD_COUNT, 5'd16);
        end else if (r == 0) begin
          write_reg(lpa_pkg::CFG_CHILD_COUNT, 5'($urandom_range(17, 31)));
        end else if (r == 1) begin
          write_reg(lpa_pkg::CFG_CHILD_COUNT, 5'd1);
        end else begin
          write_reg(lpa_pkg::CFG_CHILD_COUNT, 5'($urandom_range(2, 16)));
        end
        write_reg(lpa_pkg::CFG_DYNAMIC_MODE,
                  {4'($urandom_range(0, 15)), phase[0] ^ 1'b1});
        write_reg(lpa_pkg::CFG_REVERSE_DIRECTION, 5'($urandom_range(0, 31)));
      end
      steady = (phase == 2);
      for (j = 0; j < 75; j++) begin
        send_request(random_mask());
        if (phase == 3 && j == 37) begin
          drain_grants();
        end
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    request_mask_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_wdata_i <= '0;
    arb_count = '0;
    arb_dynamic = 1'b0;
    arb_reverse = 1'b0;
    rank_built = 1'b0;
    mismatch_count = 0;
    steady = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_static_priority();
    test_dynamic_rotation();
    test_random_traffic();
    drain_grants();
    repeat (5) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/lpa_pkg.sv
rtl/lpa_cell.sv
rtl/lru_priority_arbiter_unit.sv
rtl/lpa_checker.sv
tb/lru_priority_arbiter_unit_test.sv
